// ===== hw/rtl/kpst_pkg.sv =====
// ----------------------------------------------------------------------------
// kpst_pkg
// Types and codes for the key press slot tracker, its slot memory words and its testbench.
// ----------------------------------------------------------------------------
package kpst_pkg;

  typedef enum logic [2:0] {
    OP_PRESS   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_EXPIRE  = 3'd2,
    OP_TICK    = 3'd3,
    OP_QUERY   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_RDX,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SS_EXPIRED  = 2'd0,
    SS_PRESSED  = 2'd1,
    SS_RELEASED = 2'd2
  } slot_state_t;

  // one word of the slot memory
  typedef struct packed {
    logic [31:0]        mark;
    logic [31:0]        elapsed;
    logic [7:0]         vel;
    logic signed [8:0]  key;
  } slot_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic [31:0]        since_release;
    logic [7:0]         slot_velocity;
    logic signed [8:0]  slot_key;
    logic [1:0]         slot_state;
    logic               key_found;
    logic               any_pressed;
    logic               press_taken;
    logic [3:0]         taken_slot;
  } res_t;

endpackage

// ===== hw/rtl/kpst_ram.sv =====
// ----------------------------------------------------------------------------
// kpst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/key_press_slot_tracker.sv =====
// ----------------------------------------------------------------------------
// key_press_slot_tracker
// Table of key press slots: press, release, expire, tick, key query, readout.
// ----------------------------------------------------------------------------
// One beat is taken at a time; in_tready is low from acceptance until the
// result beat has been taken. Press, release, tick and key query walk the
// slot memory through its single read port, one slot per cycle, before the
// result beat is offered. A slot readout reads the selected slot and then
// offers its result; expire or an unused op code goes straight to the result
// beat. Expired, pressed and written flags live in flip-flops that reset
// loads at once, so there is no clearing pass: every slot is free right
// after reset and a slot never pressed reads as zero.
module key_press_slot_tracker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // key_offset
  input  logic        in_tvalid,
  output logic        in_tready,
  // key_value[7:0], key_is_offset[8], velocity[16:9], slot_select[24:17],
  // tick_amount[40:25], count_released[41], zero[47:42]
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,      // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // taken_slot[3:0], press_taken[4], any_pressed[5], key_found[6],
  // slot_state[8:7], slot_key[17:9], slot_velocity[25:18],
  // since_release[57:26], zero[63:58]
  output logic [63:0] out_tdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  kpst_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pv_r, pv_nxt;
  logic [AW-1:0]    pidx_r, pidx_nxt;
  logic             found_r, found_nxt;
  logic [SLOTS-1:0] exp_r, exp_nxt;
  logic [SLOTS-1:0] wr_r, wr_nxt;
  logic [SLOTS-1:0] mz_r, mz_nxt;
  kpst_pkg::res_t   res_r, res_nxt;
  logic [7:0]       koff_r;

  kpst_pkg::op_t    op_r;
  logic signed [8:0] key_r;
  logic [7:0]       vel_r;
  logic [7:0]       sel_r;
  logic [15:0]      amt_r;
  logic             incl_r;

  logic             in_fire;
  kpst_pkg::op_t    in_op;
  logic [7:0]       in_key;
  logic             in_is_off;
  logic [7:0]       in_sel;
  logic signed [8:0] raw_key;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  kpst_pkg::slot_t  ram_wdata, ram_rdata, cur;
  logic [AW-1:0]    cidx;

  logic [31:0]      add_b;
  logic             add_cin;
  logic [32:0]      sum;
  logic [31:0]      tick_sat;
  logic             key_hit;
  logic             sel_ok;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == kpst_pkg::ST_IDLE);
  assign in_op     = kpst_pkg::op_t'(in_tuser);
  assign in_key    = in_tdata[7:0];
  assign in_is_off = in_tdata[8];
  assign in_sel    = in_tdata[24:17];
  assign raw_key   = $signed({in_key[7], in_key}) +
                     (in_is_off ? $signed({koff_r[7], koff_r}) : 9'sd0);

  kpst_ram #(
    .WIDTH ($bits(kpst_pkg::slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a slot never pressed reads as all zero
  assign cidx = (state_r == kpst_pkg::ST_RDX) ? sel_r[AW-1:0] : pidx_r;
  assign cur  = wr_r[cidx] ? ram_rdata : '0;

  // shared adder: saturating tick add, or elapsed minus mark on readout
  assign add_b    = (op_r == kpst_pkg::OP_TICK) ? {16'd0, amt_r} : ~cur.mark;
  assign add_cin  = (op_r == kpst_pkg::OP_READ);
  assign sum      = {1'b0, cur.elapsed} + {1'b0, add_b} + {32'd0, add_cin};
  assign tick_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign key_hit  = (cur.key == key_r);
  assign sel_ok   = (sel_r < 8'(SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kpst_pkg::ST_IDLE;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
      exp_r   <= '1;
      wr_r    <= '0;
      mz_r    <= '1;
      koff_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      found_r <= found_nxt;
      exp_r   <= exp_nxt;
      wr_r    <= wr_nxt;
      mz_r    <= mz_nxt;
      if (cfg_we) begin
        koff_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    res_r  <= res_nxt;
    if (in_fire) begin
      op_r   <= in_op;
      key_r  <= raw_key;
      vel_r  <= in_tdata[16:9];
      sel_r  <= in_sel;
      amt_r  <= in_tdata[40:25];
      incl_r <= in_tdata[41];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pv_nxt    = 1'b0;
    pidx_nxt  = pidx_r;
    found_nxt = found_r;
    exp_nxt   = exp_r;
    wr_nxt    = wr_r;
    mz_nxt    = mz_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = pidx_r;
    ram_wdata = cur;
    ram_raddr = cnt_r[AW-1:0];

    unique case (state_r)
      kpst_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          case (in_op)
            kpst_pkg::OP_PRESS, kpst_pkg::OP_RELEASE,
            kpst_pkg::OP_TICK, kpst_pkg::OP_QUERY: begin
              state_nxt = kpst_pkg::ST_SCAN;
            end
            kpst_pkg::OP_EXPIRE: begin
              if (in_sel < 8'(SLOTS)) begin
                exp_nxt[in_sel[AW-1:0]] = 1'b1;
              end
              state_nxt = kpst_pkg::ST_OUT;
            end
            kpst_pkg::OP_READ: begin
              state_nxt = kpst_pkg::ST_RD;
            end
            default: begin
              state_nxt = kpst_pkg::ST_OUT;
            end
          endcase
        end
      end

      kpst_pkg::ST_SCAN: begin
        // read slot cnt while the slot read last cycle is processed
        if (cnt_r < CW'(SLOTS)) begin
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (pv_r) begin
          case (op_r)
            kpst_pkg::OP_PRESS: begin
              if (!found_r && exp_r[pidx_r]) begin
                ram_we            = 1'b1;
                ram_wdata.mark    = '0;
                ram_wdata.elapsed = '0;
                ram_wdata.vel     = vel_r;
                ram_wdata.key     = key_r;
                exp_nxt[pidx_r]   = 1'b0;
                wr_nxt[pidx_r]    = 1'b1;
                mz_nxt[pidx_r]    = 1'b1;
                found_nxt         = 1'b1;
                res_nxt.taken_slot  = 4'(pidx_r);
                res_nxt.press_taken = 1'b1;
              end
            end
            kpst_pkg::OP_RELEASE: begin
              if (key_hit && !exp_r[pidx_r] && mz_r[pidx_r]) begin
                ram_we         = 1'b1;
                ram_wdata.mark = cur.elapsed;
                // release at time zero leaves the slot pressed
                mz_nxt[pidx_r] = (cur.elapsed == 32'd0);
              end
            end
            kpst_pkg::OP_TICK: begin
              if (!exp_r[pidx_r]) begin
                ram_we            = 1'b1;
                ram_wdata.elapsed = tick_sat;
              end
            end
            kpst_pkg::OP_QUERY: begin
              if (key_hit && !exp_r[pidx_r] && (mz_r[pidx_r] || incl_r)) begin
                res_nxt.key_found = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if ((cnt_r == CW'(SLOTS)) && !pv_r) begin
          state_nxt = kpst_pkg::ST_OUT;
        end
      end

      kpst_pkg::ST_RD: begin
        ram_raddr = sel_r[AW-1:0];
        state_nxt = kpst_pkg::ST_RDX;
      end

      kpst_pkg::ST_RDX: begin
        res_nxt.taken_slot = sel_r[3:0];
        if (sel_ok) begin
          res_nxt.slot_key      = cur.key;
          res_nxt.slot_velocity = cur.vel;
          if (exp_r[cidx]) begin
            res_nxt.slot_state    = kpst_pkg::SS_EXPIRED;
            res_nxt.since_release = sum[31:0];
          end else if (mz_r[cidx]) begin
            res_nxt.slot_state    = kpst_pkg::SS_PRESSED;
            res_nxt.since_release = '0;
          end else begin
            res_nxt.slot_state    = kpst_pkg::SS_RELEASED;
            res_nxt.since_release = sum[31:0];
          end
        end
        state_nxt = kpst_pkg::ST_OUT;
      end

      kpst_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = kpst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = kpst_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = (state_r == kpst_pkg::ST_OUT);

  // flags are stable while the result beat waits
  always_comb begin
    kpst_pkg::res_t res_o;
    res_o             = res_r;
    res_o.any_pressed = |(mz_r & ~exp_r);
    out_tdata         = {6'd0, res_o};
  end

  // a slot that was never pressed is always free
  a_unwritten_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((~wr_r & ~exp_r) == '0))
    else $error("unwritten slot is not expired");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(SLOTS)))
    else $error("scan counter beyond slot count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  a_press_query_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res_r.press_taken && res_r.key_found))
    else $error("press and key query flags both set");

  a_press_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpst_pkg::ST_SCAN && pv_r && op_r == kpst_pkg::OP_PRESS &&
     !found_r && exp_r[pidx_r]) |=> (!exp_r[$past(pidx_r)] && found_r))
    else $error("press did not claim the free slot");

endmodule

// ===== tb/tb_key_press_slot_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_key_press_slot_tracker
// Streams press, release, expire, tick, key query and slot readout beats into
// the tracker. A shadow slot table predicts every result beat, and a monitor
// compares each one field by field. Phases with different key offsets include
// a long receiver stall and a run of full-scale ticks after the table is filled.
// ----------------------------------------------------------------------------
module tb_key_press_slot_tracker;

  localparam int SLOTS = 16;
  localparam int unsigned CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]        op;
    logic signed [7:0] key_value;
    logic              key_is_offset;
    logic [7:0]        velocity;
    logic [7:0]        slot_select;
    logic [15:0]       tick_amount;
    logic              count_released;
  } key_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  // shadow slot table
  logic signed [7:0] key_offset_shadow;
  logic signed [8:0] held_key  [SLOTS];
  logic [7:0]        held_vel  [SLOTS];
  logic [31:0]       held_time [SLOTS];
  logic [31:0]       held_mark [SLOTS];
  logic              slot_free [SLOTS];

  key_event_t     queued_events[$];
  kpst_pkg::res_t expected_slot_reports[$];
  key_event_t     cur_event;
  int             key_pool [8];

  logic        in_offering = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          rx_hold_cycles = 0;
  logic        idle_en = 1'b0;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  key_press_slot_tracker #(.SLOTS(SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic key_event_t mk_event(input logic [2:0] op, input int key, input bit offs,
                                          input int vel, input int sel, input int amt,
                                          input bit incl);
    key_event_t ev;
    ev.op = op;
    ev.key_value = key[7:0];
    ev.key_is_offset = offs;
    ev.velocity = vel[7:0];
    ev.slot_select = sel[7:0];
    ev.tick_amount = amt[15:0];
    ev.count_released = incl;
    return ev;
  endfunction

  function automatic key_event_t random_key_event(input int press_pct);
    key_event_t ev;
    int pick;
    int raw;
    int v;
    pick = $urandom_range(0, press_pct + 77);
    if (pick < press_pct) ev.op = kpst_pkg::OP_PRESS;
    else if (pick < press_pct + 15) ev.op = kpst_pkg::OP_RELEASE;
    else if (pick < press_pct + 27) ev.op = kpst_pkg::OP_EXPIRE;
    else if (pick < press_pct + 45) ev.op = kpst_pkg::OP_TICK;
    else if (pick < press_pct + 58) ev.op = kpst_pkg::OP_QUERY;
    else if (pick < press_pct + 75) ev.op = kpst_pkg::OP_READ;
    else ev.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    // mostly keys from a small pool so releases and queries find held slots,
    // reached in raw or offset form whichever fits in eight bits
    if ($urandom_range(0, 4) != 0) begin
      raw = key_pool[$urandom_range(0, 7)];
      v = raw - int'(key_offset_shadow);
      if ($urandom_range(0, 1) && v >= -128 && v <= 127) begin
        ev.key_is_offset = 1'b1;
      end else if (raw >= -128 && raw <= 127) begin
        ev.key_is_offset = 1'b0;
        v = raw;
      end else begin
        ev.key_is_offset = 1'b1;
      end
      ev.key_value = v[7:0];
    end else begin
      ev.key_value = 8'($urandom);
      ev.key_is_offset = 1'($urandom);
    end
    ev.velocity = 8'($urandom_range(0, 255));
    ev.slot_select = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, SLOTS - 1))
                                                 : 8'($urandom_range(SLOTS, 255));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: ev.tick_amount = 16'($urandom_range(0, 300));
      6, 7:             ev.tick_amount = 16'hffff;
      default:          ev.tick_amount = 16'($urandom);
    endcase
    ev.count_released = 1'($urandom);
    return ev;
  endfunction

  task automatic queue_event(input key_event_t ev);
    queued_events.insert(queued_events.size(), ev);
  endtask

  // advances the shadow table by one beat and queues the result it should give
  task automatic apply_key_event(input key_event_t ev);
    kpst_pkg::res_t r;
    logic signed [8:0] raw;
    logic [32:0] sum;
    int i;
    r = '0;
    raw = {ev.key_value[7], ev.key_value};
    if (ev.key_is_offset) raw = raw + {key_offset_shadow[7], key_offset_shadow};
    case (ev.op)
      kpst_pkg::OP_PRESS: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_free[i] && !r.press_taken) begin
            held_key[i] = raw;
            held_vel[i] = ev.velocity;
            held_time[i] = '0;
            held_mark[i] = '0;
            slot_free[i] = 1'b0;
            r.taken_slot = 4'(i);
            r.press_taken = 1'b1;
          end
        end
      end
      kpst_pkg::OP_RELEASE: begin
        for (i = 0; i < SLOTS; i++)
          if (!slot_free[i] && held_mark[i] == 0 && held_key[i] == raw)
            held_mark[i] = held_time[i];
      end
      kpst_pkg::OP_EXPIRE: begin
        if (ev.slot_select < SLOTS) slot_free[ev.slot_select] = 1'b1;
      end
      kpst_pkg::OP_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_free[i]) begin
            sum = {1'b0, held_time[i]} + {17'b0, ev.tick_amount};
            held_time[i] = sum[32] ? '1 : sum[31:0];
          end
        end
      end
      kpst_pkg::OP_QUERY: begin
        for (i = 0; i < SLOTS; i++)
          if (!slot_free[i] && held_key[i] == raw &&
              (held_mark[i] == 0 || ev.count_released))
            r.key_found = 1'b1;
      end
      kpst_pkg::OP_READ: begin
        r.taken_slot = ev.slot_select[3:0];
        if (ev.slot_select < SLOTS) begin
          if (slot_free[ev.slot_select]) r.slot_state = kpst_pkg::SS_EXPIRED;
          else if (held_mark[ev.slot_select] == 0) r.slot_state = kpst_pkg::SS_PRESSED;
          else r.slot_state = kpst_pkg::SS_RELEASED;
          r.slot_key = held_key[ev.slot_select];
          r.slot_velocity = held_vel[ev.slot_select];
          if (r.slot_state != kpst_pkg::SS_PRESSED)
            r.since_release = held_time[ev.slot_select] - held_mark[ev.slot_select];
        end
      end
      default: ;
    endcase
    for (i = 0; i < SLOTS; i++)
      if (!slot_free[i] && held_mark[i] == 0) r.any_pressed = 1'b1;
    expected_slot_reports.insert(expected_slot_reports.size(), r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic write_key_offset(input logic signed [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_offset_shadow = value;
    @(negedge clk);
  endtask

  task automatic drain();
    while (queued_events.size() != 0 || in_offering || expected_slot_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random_phase(input int count, input int press_pct);
    int k;
    for (k = 0; k < 8; k++)
      key_pool[k] = ($urandom_range(0, 255) - 128)
                  + ($urandom_range(0, 1) ? int'(key_offset_shadow) : 0);
    for (k = 0; k < count; k++) queue_event(random_key_event(press_pct));
  endtask

  // driver: one beat offered at a time from the queue, with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_offering && in_tready) begin
        apply_key_event(cur_event);
        in_offering = 1'b0;
      end
      if (!in_offering) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (queued_events.size() != 0) begin
          if (idle_en && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(0, 17);
          end else begin
            cur_event = queued_events.pop_front();
            in_offering = 1'b1;
            in_tdata <= {6'b0, cur_event.count_released, cur_event.tick_amount,
                         cur_event.slot_select, cur_event.velocity, cur_event.key_is_offset,
                         cur_event.key_value};
            in_tuser <= cur_event.op;
          end
        end
      end
      in_tvalid <= in_offering;
    end
  end

  always @(posedge clk) begin
    if (rx_hold_cycles != 0) rx_hold_cycles <= rx_hold_cycles - 1;
  end

  // monitor: checks each result beat and drives backpressure
  always @(posedge clk) begin : monitor
    kpst_pkg::res_t got;
    kpst_pkg::res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_slot_reports.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata, '0);
        end else begin
          want = expected_slot_reports.pop_front();
          got = kpst_pkg::res_t'(out_tdata[57:0]);
          if (got.taken_slot !== want.taken_slot)
            report_mismatch("taken_slot", 64'(got.taken_slot), 64'(want.taken_slot));
          if (got.press_taken !== want.press_taken)
            report_mismatch("press_taken", 64'(got.press_taken), 64'(want.press_taken));
          if (got.any_pressed !== want.any_pressed)
            report_mismatch("any_pressed", 64'(got.any_pressed), 64'(want.any_pressed));
          if (got.key_found !== want.key_found)
            report_mismatch("key_found", 64'(got.key_found), 64'(want.key_found));
          if (got.slot_state !== want.slot_state)
            report_mismatch("slot_state", 64'(got.slot_state), 64'(want.slot_state));
          if (got.slot_key !== want.slot_key)
            report_mismatch("slot_key", 64'(got.slot_key), 64'(want.slot_key));
          if (got.slot_velocity !== want.slot_velocity)
            report_mismatch("slot_velocity", 64'(got.slot_velocity),
                            64'(want.slot_velocity));
          if (got.since_release !== want.since_release)
            report_mismatch("since_release", 64'(got.since_release),
                            64'(want.since_release));
          if (out_tdata[63:58] !== '0)
            report_mismatch("padding", 64'(out_tdata[63:58]), '0);
        end
      end
      if (rx_hold_cycles != 0) begin
        out_tready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    key_offset_shadow = '0;
    for (i = 0; i < SLOTS; i++) begin
      held_key[i] = '0;
      held_vel[i] = '0;
      held_time[i] = '0;
      held_mark[i] = '0;
      slot_free[i] = 1'b1;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_en = 1'b1;

    // directed: field extremes, every op, the corner cases
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_PRESS, 127, 0, 255, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_PRESS, -128, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_PRESS, 5, 1, 128, 0, 0, 0));
    // released at time zero: mark stays zero, slot stays pressed
    queue_event(mk_event(kpst_pkg::OP_RELEASE, 5, 1, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_TICK, 0, 0, 0, 0, 65535, 0));
    queue_event(mk_event(kpst_pkg::OP_RELEASE, 127, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_TICK, 0, 0, 0, 0, 1, 0));
    queue_event(mk_event(kpst_pkg::OP_QUERY, 127, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_QUERY, 127, 0, 0, 0, 0, 1));
    queue_event(mk_event(kpst_pkg::OP_QUERY, -128, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 2, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, 1, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 1, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, 16, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, 255, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 255, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 16, 0, 0));
    queue_event(mk_event(OP_SPARE6, -1, 1, 255, 255, 65535, 1));
    queue_event(mk_event(OP_SPARE7, 0, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_PRESS, -1, 1, 255, 255, 65535, 1));
    queue_event(mk_event(kpst_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, 2, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, 1, 0, 0));
    drain();

    // long receiver stall while the sender keeps offering
    write_key_offset(8'sd127);
    run_random_phase(420, 30);
    rx_hold_cycles = 400;
    drain();

    write_key_offset(-8'sd128);
    run_random_phase(420, 15);
    drain();

    // fill the table, overflow it, then run full-scale ticks on the held timers
    write_key_offset(-8'sd1);
    idle_en = 1'b0;
    for (i = 0; i < SLOTS; i++) queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, i, 0, 0));
    for (i = 0; i < SLOTS; i++)
      queue_event(mk_event(kpst_pkg::OP_PRESS, i * 17 - 128, i[0], i * 16 + 15, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_PRESS, 3, 0, 77, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_TICK, 0, 0, 0, 0, 1000, 0));
    for (i = 0; i < 6; i++)
      queue_event(mk_event(kpst_pkg::OP_RELEASE, i * 17 - 128, i[0], 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_EXPIRE, 0, 0, 0, SLOTS - 1, 0, 0));
    for (i = 0; i < 60; i++) queue_event(mk_event(kpst_pkg::OP_TICK, 0, 0, 0, 0, 65535, 0));
    for (i = 0; i < SLOTS; i++) queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, i, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_QUERY, -128, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_QUERY, -128, 0, 0, 0, 0, 1));
    queue_event(mk_event(kpst_pkg::OP_RELEASE, 8, 0, 0, 0, 0, 0));
    queue_event(mk_event(kpst_pkg::OP_READ, 0, 0, 0, 8, 0, 0));
    drain();

    idle_en = 1'b1;
    write_key_offset(8'($urandom));
    run_random_phase(450, 25);
    drain();

    // closing stretch runs at full rate on both sides
    idle_en = 1'b0;
    write_key_offset(8'sd0);
    run_random_phase(420, 22);
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kpst_pkg.sv
hw/rtl/kpst_ram.sv
hw/rtl/key_press_slot_tracker.sv
tb/tb_key_press_slot_tracker.sv
